// ===== src/assert_macros.svh =====
// Assertion macros shared by the sampler RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define NRS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in a cycle implies the consequent in the same cycle
`define NRS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in a cycle implies the consequent in the next cycle
`define NRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/nrs_pkg.sv =====
// Shared types and constants for the rejection sampler.
// No dependencies; imported by every sampler module.
`default_nettype none

package nrs_pkg;

    localparam int unsigned CAND_W    = 12;
    localparam int unsigned MOD_W     = 13;
    localparam int unsigned IDX_W     = 8;
    localparam int unsigned PAD_W     = 9;
    localparam int unsigned IN_DATA_W = 24;
    localparam int unsigned OUT_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [3:0]       NIBBLE_MASK   = 4'hF;
    localparam logic [MOD_W-1:0] MODULUS_RESET = 13'd3329;

    // Register word index taken from paddr[2]
    localparam logic REG_MODULUS = 1'b0;

    // One classified byte group handed from front to back
    typedef struct packed {
        logic [CAND_W-1:0] cand_lo;
        logic [CAND_W-1:0] cand_hi;
        logic              acc_lo;
        logic              acc_hi;
        logic              final_group;
    } nrs_entry_t;

endpackage

`default_nettype wire

// ===== src/ntt_rejection_sampler.sv =====
// Rejection sampler for NTT-domain polynomial coefficients.
//
// Input stream s_axis_*: one three-byte XOF group per item, tlast marks the
// final group of a polynomial. Output stream m_axis_*: one result per item,
// either an accepted coefficient with its index or, on a final group that
// leaves the polynomial short, a padding report giving the first padded index
// and how many zeros follow; tlast flags the result that completes a polynomial.
// APB port: register 0 (address 0) holds the 13-bit acceptance modulus.
// Accepted groups are stored in the queue; their results are then registered.
// Throughput: one group per cycle while each group yields at most one result
// and the receiver is ready. The back end drains one result per cycle through
// its output register while m_axis_tready is high, so a group with two or three
// results holds it until all are out, buffered by a two-entry queue before it.
// Reset: modulus returns to 3329, the coefficient count to zero, queue empties.
// Receiver stall: the output register holds, the back end stops, the queue
// fills, then s_axis_tready drops.
// Depends on nrs_pkg, nrs_front, nrs_queue and nrs_back.
`default_nettype none

module ntt_rejection_sampler #(
    parameter int unsigned COEFFS_PER_POLY = 256
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // [7:0] byte_lo, [15:8] byte_mid, [23:16] byte_hi
    input  wire logic [nrs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic                            s_axis_tvalid,
    input  wire logic                            s_axis_tlast,
    output logic                                 s_axis_tready,
    // [11:0] coefficient, [19:12] coeff_index, [28:20] pad_zeros, [31:29] zero
    output logic [nrs_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                 m_axis_tvalid,
    output logic                                 m_axis_tlast,
    input  wire logic                            m_axis_tready,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [nrs_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [nrs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [nrs_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import nrs_pkg::*;

    logic [MOD_W-1:0] modulus_reg;
    logic [MOD_W-1:0] modulus_next;
    logic             cfg_write;
    logic             push;
    logic             pop;
    logic             queue_full;
    logic             head_valid;
    nrs_entry_t       push_entry;
    nrs_entry_t       head_entry;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        modulus_next = modulus_reg;
        if (cfg_write && (paddr[2] == REG_MODULUS))
        begin
            modulus_next = pwdata[MOD_W-1:0];
        end
        prdata = '0;
        if (paddr[2] == REG_MODULUS)
        begin
            prdata = APB_DATA_W'(modulus_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
        end
        else
        begin
            modulus_reg <= modulus_next;
        end
    end

    nrs_front u_front (
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .modulus       (modulus_reg),
        .queue_full    (queue_full),
        .push          (push),
        .entry         (push_entry)
    );

    nrs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    nrs_back #(
        .COEFFS_PER_POLY (COEFFS_PER_POLY)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_entry    (head_entry),
        .pop           (pop),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tready (m_axis_tready)
    );

endmodule

`default_nettype wire

// ===== src/nrs_front.sv =====
// Front end: splits a byte group into two candidates and tests each against the modulus.
// Depends on nrs_pkg.
`default_nettype none

module nrs_front (
    input  wire logic [nrs_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tlast,
    output logic                               s_axis_tready,
    input  wire logic [nrs_pkg::MOD_W-1:0]     modulus,
    input  wire logic                          queue_full,
    output logic                               push,
    output nrs_pkg::nrs_entry_t                entry
);
    import nrs_pkg::*;

    logic [7:0] byte_lo;
    logic [7:0] byte_mid;
    logic [7:0] byte_hi;

    // Unpack the group
    assign byte_lo  = s_axis_tdata[7:0];
    assign byte_mid = s_axis_tdata[15:8];
    assign byte_hi  = s_axis_tdata[23:16];

    // Build the candidates and classify them
    always_comb
    begin
        entry.cand_lo     = {byte_mid[3:0] & NIBBLE_MASK, byte_lo};
        entry.cand_hi     = {byte_hi, byte_mid[7:4]};
        entry.acc_lo      = {1'b0, entry.cand_lo} < modulus;
        entry.acc_hi      = {1'b0, entry.cand_hi} < modulus;
        entry.final_group = s_axis_tlast;
    end

    // Accept whenever the queue has space
    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

endmodule

`default_nettype wire

// ===== src/nrs_queue.sv =====
// Two-entry queue of classified groups between front and back.
// Depends on nrs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nrs_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire nrs_pkg::nrs_entry_t push_entry,
    input  wire logic                pop,
    output logic                     full,
    output logic                     head_valid,
    output nrs_pkg::nrs_entry_t      head_entry
);
    import nrs_pkg::*;

    nrs_entry_t  slots_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_entry = slots_reg[rd_ptr_reg];

    `NRS_ASSERT_IMPLIES(a_no_underflow, pop, count_reg != 2'd0, "queue popped while empty")
    `NRS_ASSERT_IMPLIES(a_no_overflow, push, count_reg != 2'd2, "queue pushed while full")

endmodule

`default_nettype wire

// ===== src/nrs_back.sv =====
// Back end: walks each queued group, numbers accepted coefficients, emits padding reports.
// Depends on nrs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nrs_back #(
    parameter int unsigned COEFFS_PER_POLY = 256
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           head_valid,
    input  wire nrs_pkg::nrs_entry_t            head_entry,
    output logic                                pop,
    output logic [nrs_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tvalid,
    output logic                                m_axis_tlast,
    input  wire logic                           m_axis_tready
);
    import nrs_pkg::*;

    localparam int unsigned CW = $clog2(COEFFS_PER_POLY + 1);
    localparam logic [CW-1:0] N_C = CW'(COEFFS_PER_POLY);

    // Next result slot of the head group
    typedef enum logic [2:0] {
        SLOT_D1  = 3'b001,
        SLOT_D2  = 3'b010,
        SLOT_PAD = 3'b100
    } slot_t;

    slot_t             slot_reg;
    slot_t             slot_next;
    logic [CW-1:0]     fc_reg;
    logic [CW-1:0]     fc_next;
    logic [CW-1:0]     fc_plus;
    logic [31:0]       fc_wide;
    logic [31:0]       pad_wide;
    logic              has_room;
    logic              room_after;
    logic              c_lo;
    logic              c_hi;
    logic              c_pad;
    logic              any_result;
    logic              more;
    logic              out_free;
    logic              emit;
    logic              emit_coef;
    logic [CAND_W-1:0] res_coef;
    logic [PAD_W-1:0]  res_pad;
    logic              res_last;
    logic              out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic              out_last_reg;

    // Room checks on the current count
    always_comb
    begin
        fc_plus    = fc_reg + CW'(1);
        has_room   = fc_reg < N_C;
        room_after = fc_plus < N_C;
        fc_wide    = 32'(fc_reg);
        pad_wide   = 32'(N_C - fc_reg);
    end

    // Pick the first pending result of the head group
    always_comb
    begin
        c_lo  = (slot_reg == SLOT_D1) && head_entry.acc_lo && has_room;
        c_hi  = ((slot_reg == SLOT_D1) || (slot_reg == SLOT_D2))
                && head_entry.acc_hi && has_room;
        c_pad = head_entry.final_group && has_room;
        any_result = head_valid && (c_lo || c_hi || c_pad);

        res_coef  = '0;
        res_pad   = '0;
        res_last  = 1'b0;
        emit_coef = 1'b0;
        more      = 1'b0;
        slot_next = slot_reg;
        if (c_lo)
        begin
            res_coef  = head_entry.cand_lo;
            res_last  = fc_plus == N_C;
            emit_coef = 1'b1;
            more      = room_after && (head_entry.acc_hi || head_entry.final_group);
            slot_next = SLOT_D2;
        end
        else if (c_hi)
        begin
            res_coef  = head_entry.cand_hi;
            res_last  = fc_plus == N_C;
            emit_coef = 1'b1;
            more      = room_after && head_entry.final_group;
            slot_next = SLOT_PAD;
        end
        else
        begin
            res_pad  = pad_wide[PAD_W-1:0];
            res_last = 1'b1;
        end

        out_free = !out_valid_reg || m_axis_tready;
        emit     = any_result && out_free;
        pop      = head_valid && (!any_result || (out_free && !more));

        // Update the count and slot
        fc_next = fc_reg;
        if (pop)
        begin
            slot_next = SLOT_D1;
            if (head_entry.final_group)
            begin
                fc_next = '0;
            end
            else if (emit && emit_coef)
            begin
                fc_next = fc_plus;
            end
        end
        else
        begin
            if (emit && emit_coef)
            begin
                fc_next = fc_plus;
            end
            if (!emit)
            begin
                slot_next = slot_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= SLOT_D1;
            fc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg <= slot_next;
            fc_reg   <= fc_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= {3'b000, res_pad, fc_wide[IDX_W-1:0], res_coef};
            out_last_reg <= res_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    `NRS_ASSERT_ALWAYS(a_count_bound, fc_reg <= N_C, "coefficient count above polynomial size")
    `NRS_ASSERT_IMPLIES(a_pad_is_last,
        m_axis_tvalid && (m_axis_tdata[28:20] != 9'd0), m_axis_tlast,
        "padding report without last")
    `NRS_ASSERT_NEXT(a_pop_resets_slot, pop, slot_reg == SLOT_D1,
        "slot not rewound after group retired")

endmodule

`default_nettype wire
